// ===== rtl/u8dr_pkg.sv =====
// Shared types and constants for the UTF-8 decoder with replacement character.
package u8dr_pkg;

   localparam int ByteWidth = 8;
   localparam int CodeWidth = 21;
   localparam int CountWidth = 2;
   localparam int RspDataWidth = 24;   // codepoint padded to whole bytes
   localparam int DefaultQueueDepth = 4;

   localparam logic [CodeWidth-1:0] ReplCode = 21'h00FFFD;

   // req_tuser codes
   localparam logic ActDecode = 1'b0;
   localparam logic ActEnd = 1'b1;

   // Work for the back end: n_repl replacement results, then an optional tail result.
   typedef struct packed {
      logic [CountWidth-1:0] n_repl;
      logic                  has_tail;
      logic [CodeWidth-1:0]  tail_code;
      logic                  tail_repl;
   } job_type;

endpackage

// ===== rtl/u8dr_front.sv =====
// Front end: takes byte transfers, tracks the open sequence and issues jobs.
module u8dr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_action,
   input  logic [u8dr_pkg::ByteWidth-1:0] in_byte,
   input  logic                        q_full,
   output logic                        in_ready,
   output logic                        push,
   output u8dr_pkg::job_type           job
);

   logic [u8dr_pkg::CountWidth-1:0] expected_ff, expected_in;
   logic [u8dr_pkg::CountWidth-1:0] taken_ff, taken_in;
   logic [u8dr_pkg::CodeWidth-1:0]  acc_ff, acc_in;
   logic                            accept;
   logic                            is_cont;
   logic [u8dr_pkg::CountWidth-1:0] taken_inc;
   logic [u8dr_pkg::CodeWidth-1:0]  acc_shift;

   assign in_ready = !q_full;
   assign accept = in_valid && in_ready;
   assign is_cont = (in_byte[7:6] == 2'b10);
   assign taken_inc = taken_ff + 2'd1;
   assign acc_shift = {acc_ff[u8dr_pkg::CodeWidth-7:0], in_byte[5:0]};

   always_comb begin
      expected_in = expected_ff;
      taken_in = taken_ff;
      acc_in = acc_ff;
      job.n_repl = '0;
      job.has_tail = 1'b0;
      job.tail_code = {{(u8dr_pkg::CodeWidth-u8dr_pkg::ByteWidth){1'b0}}, in_byte};
      job.tail_repl = 1'b0;
      if (in_action == u8dr_pkg::ActEnd) begin
         if (expected_ff != '0) begin
            job.n_repl = taken_inc;
            expected_in = '0;
            taken_in = '0;
            acc_in = '0;
         end
      end else if (expected_ff != '0 && is_cont) begin
         if (taken_inc >= expected_ff) begin
            job.has_tail = 1'b1;
            job.tail_code = acc_shift;
            expected_in = '0;
            taken_in = '0;
            acc_in = '0;
         end else begin
            taken_in = taken_inc;
            acc_in = acc_shift;
         end
      end else begin
         // broken sequence: lead plus taken continuations become replacements
         if (expected_ff != '0) begin
            job.n_repl = taken_inc;
            expected_in = '0;
            taken_in = '0;
            acc_in = '0;
         end
         priority if (!in_byte[7]) begin
            job.has_tail = 1'b1;
         end else if (in_byte[7:5] == 3'b110) begin
            acc_in = {{(u8dr_pkg::CodeWidth-5){1'b0}}, in_byte[4:0]};
            expected_in = 2'd1;
            taken_in = '0;
         end else if (in_byte[7:4] == 4'b1110) begin
            acc_in = {{(u8dr_pkg::CodeWidth-4){1'b0}}, in_byte[3:0]};
            expected_in = 2'd2;
            taken_in = '0;
         end else if (in_byte[7:3] == 5'b11110) begin
            acc_in = {{(u8dr_pkg::CodeWidth-3){1'b0}}, in_byte[2:0]};
            expected_in = 2'd3;
            taken_in = '0;
         end else begin
            // stray continuation or 0xF8 and above
            job.has_tail = 1'b1;
            job.tail_code = u8dr_pkg::ReplCode;
            job.tail_repl = 1'b1;
         end
      end
   end

   assign push = accept && (job.n_repl != '0 || job.has_tail);

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         taken_ff <= '0;
         acc_ff <= '0;
      end else if (accept) begin
         expected_ff <= expected_in;
         taken_ff <= taken_in;
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== rtl/u8dr_queue.sv =====
// Job queue between front and back end, register based.
module u8dr_queue #(
   parameter int Depth = u8dr_pkg::DefaultQueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u8dr_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output u8dr_pkg::job_type head_job
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(Depth);
   localparam logic [PtrWidth-1:0] PtrStep = PtrWidth'(1);
   localparam logic [CntWidth-1:0] CntStep = CntWidth'(1);

   u8dr_pkg::job_type          slot_ff [Depth];
   logic [PtrWidth-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]        count_ff;
   logic                       do_push, do_pop;

   assign full = (count_ff == FullCount);
   assign head_valid = (count_ff != '0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrStep;
         if (do_pop) rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrStep;
         if (do_push && !do_pop) count_ff <= count_ff + CntStep;
         else if (!do_push && do_pop) count_ff <= count_ff - CntStep;
      end
   end

endmodule

// ===== rtl/u8dr_back.sv =====
// Back end: expands each job into result transfers through an output register.
module u8dr_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  u8dr_pkg::job_type              head_job,
   output logic                           pop,
   input  logic                           out_ready,
   output logic                           out_valid,
   output logic [u8dr_pkg::CodeWidth-1:0] out_code,
   output logic                           out_repl,
   output logic                           out_last
);

   logic                            valid_ff;
   logic [u8dr_pkg::CodeWidth-1:0]  code_ff, code_in;
   logic                            repl_ff, repl_in;
   logic                            last_ff, last_in;
   logic [u8dr_pkg::CountWidth-1:0] idx_ff;
   logic                            load;

   assign load = head_valid && (!valid_ff || out_ready);

   always_comb begin
      if (idx_ff < head_job.n_repl) begin
         code_in = u8dr_pkg::ReplCode;
         repl_in = 1'b1;
         last_in = (idx_ff == head_job.n_repl - 2'd1) && !head_job.has_tail;
      end else begin
         code_in = head_job.tail_code;
         repl_in = head_job.tail_repl;
         last_in = 1'b1;
      end
   end

   assign pop = load && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
         if (load) idx_ff <= last_in ? '0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code_in;
         repl_ff <= repl_in;
         last_ff <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_code = code_ff;
   assign out_repl = repl_ff;
   assign out_last = last_ff;

endmodule

// ===== rtl/utf8_decode_replace.sv =====
// Top level of the streaming UTF-8 decoder with replacement character.
//
// Input stream (req_): one byte per transfer in req_tdata; req_tuser is the
// action, low to decode the byte, high for end of stream (flushes an open
// sequence as U+FFFD results, byte ignored).
// Result stream (rsp_): one codepoint per transfer in rsp_tdata[20:0];
// rsp_tuser marks a replacement for invalid input, rsp_tlast marks the final
// result caused by one input transfer. A byte may give 0 to 4 results.
// Throughput: one input transfer per cycle while the job queue has room; the
// back end issues one result per cycle while the receiver takes them, so a
// job of k results occupies it until all k are taken. A result reaches rsp_
// through the queue slot (written at the input edge), then the output register.
// Reset clears the open sequence, empties the queue and drops rsp_tvalid.
// A stalled receiver holds the output register; the queue absorbs up to
// QueueDepth further jobs, then req_tready falls until space frees up.
module utf8_decode_replace #(
   parameter int QueueDepth = u8dr_pkg::DefaultQueueDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [u8dr_pkg::ByteWidth-1:0]    req_tdata,  // [7:0] byte_value
   input  logic                              req_tuser,  // [0] action
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [u8dr_pkg::RspDataWidth-1:0] rsp_tdata,  // [20:0] codepoint, rest zero
   output logic                              rsp_tuser,  // [0] is_replacement
   output logic                              rsp_tlast   // last_of_run
);

   u8dr_pkg::job_type              push_job, head_job;
   logic                           q_push, q_pop, q_full, q_valid;
   logic [u8dr_pkg::CodeWidth-1:0] rsp_code;

   // front: classify bytes, keep sequence state
   u8dr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_action (req_tuser),
      .in_byte   (req_tdata),
      .q_full    (q_full),
      .in_ready  (req_tready),
      .push      (q_push),
      .job       (push_job)
   );

   // decoupling queue
   u8dr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   // back: one result transfer per cycle while rsp_tready allows
   u8dr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_job   (head_job),
      .pop        (q_pop),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_code   (rsp_code),
      .out_repl   (rsp_tuser),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(u8dr_pkg::RspDataWidth-u8dr_pkg::CodeWidth){1'b0}}, rsp_code};

   // replacement results always carry U+FFFD
   a_repl_code : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_code == u8dr_pkg::ReplCode))
      else $error("replacement result without U+FFFD");

   // pending work with a free output slot must show up next cycle
   a_back_moves : assert property (@(posedge clock) disable iff (reset)
      (q_valid && (!rsp_tvalid || rsp_tready)) |=> rsp_tvalid)
      else $error("back end idle with queued work");

   // reset empties the output register
   a_reset_out : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // front never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

endmodule
